### rtl/rolling_window_mean_variance_core_defines.svh
// Assertion helpers for the files that check their own logic.
`ifndef ROLLING_WINDOW_MEAN_VARIANCE_CORE_DEFINES_SVH
`define ROLLING_WINDOW_MEAN_VARIANCE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWMV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWMV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rwmv_pkg.sv
`default_nettype none
package rwmv_pkg;

  localparam int DEF_CHANNELS   = 64;
  localparam int DEF_MAX_WINDOW = 128;

  localparam int          CH_FIELD_W = 6;
  localparam int          LEN_W      = 8;
  localparam logic [7:0]  WIN_RESET  = 8'd5;
  localparam logic [7:0]  WIN_MIN    = 8'd2;
  localparam int          SUM_W      = 24;
  localparam int          SQ_W       = 38;
  localparam int          DIV_W      = 46;
  localparam int          DEN_W      = 16;

  typedef struct packed {
    logic [5:0]         channel;
    logic signed [15:0] sample;
    logic               sample_valid;
  } req_t;

  typedef struct packed {
    logic [5:0]         out_channel;
    logic signed [15:0] window_mean;
    logic [31:0]        window_variance;
    logic               stats_valid;
  } rsp_t;

  // Per-channel running state; head and counts never exceed the 8-bit window length.
  typedef struct packed {
    logic [7:0]             head;
    logic [7:0]             fill;
    logic [7:0]             vcnt;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]        sq;
  } chan_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDST,
    S_UPDATE,
    S_MUL,
    S_SUB,
    S_DIVM,
    S_DIVV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic ring_rd;
    logic update;
    logic mul;
    logic sub;
    logic start_mean;
    logic start_var;
    logic take_mean;
    logic take_var;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic stats_ok;
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

### rtl/rwmv_div.sv
`default_nettype none
module rwmv_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [rwmv_pkg::DIV_W-1:0]      dividend,
  input  wire logic [rwmv_pkg::DEN_W-1:0]      divisor,
  output logic                                 done,
  output logic [rwmv_pkg::DIV_W-1:0]           quotient
);

  localparam int CNT_W = $clog2(rwmv_pkg::DIV_W + 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [rwmv_pkg::DEN_W-1:0]    rem;
  logic [rwmv_pkg::DEN_W-1:0]    dsr;
  logic [rwmv_pkg::DEN_W:0]      trial;
  logic                          fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem, quotient[rwmv_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(rwmv_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? rwmv_pkg::DEN_W'(trial - {1'b0, dsr})
                       : trial[rwmv_pkg::DEN_W-1:0];
      quotient <= {quotient[rwmv_pkg::DIV_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

### rtl/rwmv_ctrl.sv
`default_nettype none
module rwmv_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire rwmv_pkg::status_t  status,
  output rwmv_pkg::cmd_t          cmd
);

  rwmv_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rwmv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rwmv_pkg::S_IDLE: begin
        if (req_valid) state_next = rwmv_pkg::S_RDST;
      end
      rwmv_pkg::S_RDST: begin
        state_next = status.ch_ok ? rwmv_pkg::S_UPDATE : rwmv_pkg::S_OUT;
      end
      rwmv_pkg::S_UPDATE: state_next = rwmv_pkg::S_MUL;
      rwmv_pkg::S_MUL: begin
        state_next = status.stats_ok ? rwmv_pkg::S_SUB : rwmv_pkg::S_OUT;
      end
      rwmv_pkg::S_SUB: state_next = rwmv_pkg::S_DIVM;
      rwmv_pkg::S_DIVM: begin
        if (status.div_done) state_next = rwmv_pkg::S_DIVV;
      end
      rwmv_pkg::S_DIVV: begin
        if (status.div_done) state_next = rwmv_pkg::S_OUT;
      end
      rwmv_pkg::S_OUT: begin
        if (status.out_free) state_next = rwmv_pkg::S_IDLE;
      end
      default: state_next = rwmv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      rwmv_pkg::S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      rwmv_pkg::S_RDST:   cmd.ring_rd = status.ch_ok;
      rwmv_pkg::S_UPDATE: cmd.update  = 1'b1;
      rwmv_pkg::S_MUL:    cmd.mul     = 1'b1;
      rwmv_pkg::S_SUB: begin
        cmd.sub        = 1'b1;
        cmd.start_mean = 1'b1;
      end
      rwmv_pkg::S_DIVM: begin
        cmd.take_mean = status.div_done;
        cmd.start_var = status.div_done;
      end
      rwmv_pkg::S_DIVV:   cmd.take_var = status.div_done;
      rwmv_pkg::S_OUT:    cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/rwmv_dp.sv
`default_nettype none
module rwmv_dp #(
  parameter int CHANNELS   = rwmv_pkg::DEF_CHANNELS,
  parameter int MAX_WINDOW = rwmv_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  input  wire logic [rwmv_pkg::LEN_W-1:0]  cfg_data,
  input  wire rwmv_pkg::req_t              req,
  input  wire rwmv_pkg::cmd_t              cmd,
  output rwmv_pkg::status_t                status,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output rwmv_pkg::rsp_t                   rsp
);

  localparam int CH_USED    = (CHANNELS < 64) ? CHANNELS : 64;
  localparam int CH_W       = (CH_USED > 1) ? $clog2(CH_USED) : 1;
  localparam int RING_DEPTH = CH_USED * MAX_WINDOW;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int SUM_W      = rwmv_pkg::SUM_W;
  localparam int SQ_W       = rwmv_pkg::SQ_W;
  localparam int DIV_W      = rwmv_pkg::DIV_W;
  localparam int DEN_W      = rwmv_pkg::DEN_W;

  logic [7:0]                win_len;
  logic [CH_USED-1:0]        init_bits;
  rwmv_pkg::req_t            req_r;
  rwmv_pkg::chan_state_t     st_mem [CH_USED];
  rwmv_pkg::chan_state_t     st_q;
  logic                      init_q;
  logic [16:0]               ring [RING_DEPTH];
  logic [16:0]               ring_q;
  logic [RING_AW-1:0]        ring_addr_r;
  rwmv_pkg::chan_state_t     cur_r;

  logic [7:0]                n_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [SQ_W-1:0]           sq_r;
  logic [SUM_W-1:0]          abs_sum_r;
  logic                      sum_neg_r;
  logic [DIV_W-1:0]          nsq_r;
  logic [DIV_W-1:0]          ss_r;
  logic [DEN_W-1:0]          den_r;
  logic [DIV_W-1:0]          num_r;
  logic signed [15:0]        mean_r;
  logic [31:0]               var_r;
  logic                      ok_r;

  logic [CH_W-1:0]           ch_idx;
  logic [CH_W-1:0]           cap_idx;
  rwmv_pkg::chan_state_t     cur;
  logic [7:0]                head_eff;
  logic [RING_AW-1:0]        ring_addr;

  logic                      full;
  logic                      old_v;
  logic signed [15:0]        old_s;
  logic signed [31:0]        old_sq;
  logic signed [31:0]        new_sq;
  rwmv_pkg::chan_state_t     upd;
  logic [8:0]                head_inc;
  logic [SUM_W-1:0]          abs_sum;

  logic                      div_start;
  logic [DIV_W-1:0]          div_dividend;
  logic [DEN_W-1:0]          div_divisor;
  logic                      div_done;
  logic [DIV_W-1:0]          div_q;
  logic [15:0]               mean_mag;

  assign cap_idx = req.channel[CH_W-1:0];
  assign ch_idx  = req_r.channel[CH_W-1:0];

  // Configuration register and per-channel written flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len   <= rwmv_pkg::WIN_RESET;
      init_bits <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_data < rwmv_pkg::WIN_MIN) begin
          win_len <= rwmv_pkg::WIN_MIN;
        end else if (32'(cfg_data) > MAX_WINDOW) begin
          win_len <= 8'(MAX_WINDOW);
        end else begin
          win_len <= cfg_data;
        end
        init_bits <= '0;
      end else if (cmd.update) begin
        init_bits[ch_idx] <= 1'b1;
      end
    end
  end

  // A channel not yet written since reset or the last configuration reads as zero.
  always_comb begin
    cur      = init_q ? st_q : '0;
    head_eff = (cur.head >= win_len) ? 8'd0 : cur.head;
    ring_addr = RING_AW'(32'(ch_idx) * MAX_WINDOW + 32'(head_eff));
  end

  always_comb begin
    full     = cur_r.fill >= win_len;
    old_v    = full && ring_q[16];
    old_s    = signed'(ring_q[15:0]);
    old_sq   = old_s * old_s;
    new_sq   = req_r.sample * req_r.sample;
    head_inc = {1'b0, cur_r.head} + 9'd1;
    upd      = cur_r;
    upd.head = (head_inc >= {1'b0, win_len}) ? 8'd0 : head_inc[7:0];
    upd.fill = full ? cur_r.fill : cur_r.fill + 8'd1;
    upd.sum  = cur_r.sum - (old_v ? SUM_W'(old_s) : '0)
                         + (req_r.sample_valid ? SUM_W'(req_r.sample) : '0);
    upd.sq   = cur_r.sq - (old_v ? SQ_W'(unsigned'(old_sq)) : '0)
                        + (req_r.sample_valid ? SQ_W'(unsigned'(new_sq)) : '0);
    upd.vcnt = cur_r.vcnt - 8'((old_v && cur_r.vcnt != 8'd0) ? 1 : 0)
                          + 8'(req_r.sample_valid ? 1 : 0);
    abs_sum  = sum_r[SUM_W-1] ? unsigned'(-sum_r) : unsigned'(sum_r);
  end

  // State and ring memories.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      st_q <= st_mem[cap_idx];
    end
    if (cmd.ring_rd) begin
      ring_q <= ring[ring_addr];
    end
    if (cmd.update) begin
      st_mem[ch_idx]    <= upd;
      ring[ring_addr_r] <= {req_r.sample_valid, req_r.sample};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req;
      init_q <= init_bits[cap_idx];
      mean_r <= '0;
      var_r  <= '0;
      ok_r   <= 1'b0;
    end
    if (cmd.ring_rd) begin
      cur_r       <= '{head: head_eff, fill: cur.fill, vcnt: cur.vcnt,
                       sum: cur.sum, sq: cur.sq};
      ring_addr_r <= ring_addr;
    end
    if (cmd.update) begin
      n_r   <= upd.vcnt;
      sum_r <= upd.sum;
      sq_r  <= upd.sq;
    end
    if (cmd.mul) begin
      nsq_r     <= DIV_W'(n_r) * DIV_W'(sq_r);
      ss_r      <= DIV_W'(abs_sum) * DIV_W'(abs_sum);
      den_r     <= DEN_W'(n_r) * DEN_W'(n_r - 8'd1);
      abs_sum_r <= abs_sum;
      sum_neg_r <= sum_r[SUM_W-1];
    end
    if (cmd.sub) begin
      num_r <= nsq_r - ss_r;
    end
    if (cmd.take_mean) begin
      mean_r <= signed'(sum_neg_r ? 16'(-mean_mag) : mean_mag);
    end
    if (cmd.take_var) begin
      var_r <= div_q[31:0];
      ok_r  <= 1'b1;
    end
  end

  // One divider serves the mean first and the variance after it.
  assign div_start    = cmd.start_mean | cmd.start_var;
  assign div_dividend = cmd.start_var ? num_r : DIV_W'(abs_sum_r);
  assign div_divisor  = cmd.start_var ? den_r : DEN_W'(n_r);
  assign mean_mag     = div_q[15:0];

  rwmv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Output register; the next item can be taken while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.out_channel     <= req_r.channel;
      rsp.window_mean     <= mean_r;
      rsp.window_variance <= var_r;
      rsp.stats_valid     <= ok_r;
    end
  end

  always_comb begin
    status.ch_ok    = 32'(req_r.channel) < CHANNELS;
    status.stats_ok = n_r > 8'd1;
    status.div_done = div_done;
    status.out_free = !rsp_valid || rsp_ready;
  end

endmodule
`default_nettype wire

### rtl/rolling_window_mean_variance_core.sv
// Path: an accepted item with two or more valid samples passes the state read, update, multiply and
// subtract steps and then the shared bit-serial divider, first for the mean and then for the variance.
// Items with fewer valid samples skip the divider; a channel beyond CHANNELS goes straight to output.
// One item at a time: the next item is accepted only after the result is registered, and the result
// waits in the output state while the output register is still held by the previous result.
// Reset: synchronous; window length returns to 5 and every channel starts empty.
`default_nettype none
`include "rolling_window_mean_variance_core_defines.svh"
module rolling_window_mean_variance_core #(
  parameter int CHANNELS   = rwmv_pkg::DEF_CHANNELS,
  parameter int MAX_WINDOW = rwmv_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rwmv_pkg::LEN_W-1:0]  cfg_data,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire rwmv_pkg::req_t              req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output rwmv_pkg::rsp_t                   rsp
);

  rwmv_pkg::cmd_t    cmd;
  rwmv_pkg::status_t status;

  assign cfg_ready = 1'b1;

  rwmv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rwmv_dp #(
    .CHANNELS   (CHANNELS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  `RWMV_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
    "item accepted while the previous one is still in work")
  `RWMV_ASSERT_NOW(a_nan_is_zero, rsp_valid && !rsp.stats_valid,
    rsp.window_mean == 16'sd0 && rsp.window_variance == 32'd0,
    "statistics not zero on a result without enough valid samples")
  `RWMV_ASSERT_NOW(a_take_needs_done, cmd.take_mean || cmd.take_var, status.div_done,
    "division result taken before the divider finished")

endmodule
`default_nettype wire

### tb/sv/rolling_window_mean_variance_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none

// Accepted requests go through the window model below; responses are checked in order.
class window_stats_board;
  int unsigned win_len;
  logic [16:0] ring [64][128];
  int unsigned head [64];
  int unsigned fill [64];
  longint sum [64];
  longint sq [64];
  int unsigned vcnt [64];
  rwmv_pkg::rsp_t pending_stats [$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned stats_seen;

  function new();
    win_len = 5;
    mismatches = 0;
    checked = 0;
    stats_seen = 0;
    clear_channels();
  endfunction

  function void clear_channels();
    for (int c = 0; c < 64; c++) begin
      head[c] = 0;
      fill[c] = 0;
      sum[c] = 0;
      sq[c] = 0;
      vcnt[c] = 0;
    end
  endfunction

  function void set_length(logic [7:0] value);
    int unsigned v;
    v = value;
    if (v < 2) v = 2;
    if (v > 128) v = 128;
    win_len = v;
    clear_channels();
  endfunction

  function void note_sample(rwmv_pkg::req_t r);
    rwmv_pkg::rsp_t e;
    int unsigned c;
    int unsigned h;
    int unsigned n;
    longint s;
    longint o;
    longint mean;
    longint num;
    longint den;
    c = r.channel;
    s = r.sample;
    h = head[c];
    if (h >= win_len) h = 0;
    if (fill[c] >= win_len) begin
      if (ring[c][h][16]) begin
        o = $signed(ring[c][h][15:0]);
        sum[c] -= o;
        sq[c] -= o * o;
        if (vcnt[c] > 0) vcnt[c]--;
      end
    end else begin
      fill[c]++;
    end
    ring[c][h] = {r.sample_valid, r.sample};
    if (r.sample_valid) begin
      sum[c] += s;
      sq[c] += s * s;
      vcnt[c]++;
    end
    h++;
    if (h >= win_len) h = 0;
    head[c] = h;
    e = '0;
    e.out_channel = r.channel;
    n = vcnt[c];
    if (n > 1) begin
      mean = sum[c] / longint'(n);
      num = longint'(n) * sq[c] - sum[c] * sum[c];
      den = longint'(n) * longint'(n - 1);
      e.window_mean = mean[15:0];
      e.window_variance = 32'(num / den);
      e.stats_valid = 1'b1;
    end
    pending_stats.push_back(e);
  endfunction

  function void check_stats(rwmv_pkg::rsp_t a);
    rwmv_pkg::rsp_t e;
    checked++;
    if (pending_stats.size() == 0) begin
      $error("unexpected response: channel %0d", a.out_channel);
      mismatches++;
      return;
    end
    e = pending_stats.pop_front();
    if (a.stats_valid) stats_seen++;
    if (a.out_channel !== e.out_channel) begin
      $error("out_channel: expected %0d, got %0d", e.out_channel, a.out_channel);
      mismatches++;
    end
    if (a.window_mean !== e.window_mean) begin
      $error("window_mean: expected %0d, got %0d", e.window_mean, a.window_mean);
      mismatches++;
    end
    if (a.window_variance !== e.window_variance) begin
      $error("window_variance: expected %0d, got %0d", e.window_variance,
             a.window_variance);
      mismatches++;
    end
    if (a.stats_valid !== e.stats_valid) begin
      $error("stats_valid: expected %0d, got %0d", e.stats_valid, a.stats_valid);
      mismatches++;
    end
  endfunction
endclass

module rolling_window_mean_variance_core_tb;

  localparam longint CYCLE_LIMIT = 2_000_000;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [rwmv_pkg::LEN_W-1:0] cfg_data;
  logic req_valid;
  logic req_ready;
  rwmv_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rwmv_pkg::rsp_t rsp;

  window_stats_board board;
  longint cycle_count;
  bit rsp_stall_off;
  int unsigned sent;

  rolling_window_mean_variance_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("rolling_window_mean_variance_core_tb failed");
        $finish;
      end
    end
  end

  // Response side: random stalls per item, with stretches of none.
  initial begin
    int unsigned wait_cycles;
    rsp_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = rsp_stall_off ? 0 : $urandom_range(0, 17);
      if (wait_cycles != 0) begin
        rsp_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      board.check_stats(rsp);
    end
  end

  task automatic send_sample(logic [5:0] ch, logic [15:0] s, logic v, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{channel: ch, sample: s, sample_valid: v};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.note_sample(req);
    sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (board.pending_stats.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_length(logic [7:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_length(value);
    cfg_valid <= 1'b0;
  endtask

  // Mostly valid samples over the first nch channels so windows fill and slide.
  task automatic random_phase(int unsigned count, int unsigned nch);
    logic [15:0] s;
    bit burst;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
        rsp_stall_off = burst;
      end
      case ($urandom_range(0, 3))
        0: s = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        1: s = 16'($signed($urandom_range(0, 200)) - 100);
        default: s = 16'($urandom);
      endcase
      send_sample(6'($urandom_range(0, nch - 1)), s,
                  ($urandom_range(0, 7) != 0), burst);
    end
    rsp_stall_off = 1'b0;
  endtask

  initial begin
    board = new();
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    req_valid <= 1'b0;
    req <= '0;
    rsp_stall_off = 1'b0;
    sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full-scale samples, missing samples, window slide at reset length.
    send_sample(6'd0, 16'h7fff, 1'b1, 0);
    send_sample(6'd0, 16'h8000, 1'b1, 0);
    send_sample(6'd0, 16'h0000, 1'b0, 0);
    send_sample(6'd0, 16'h8000, 1'b1, 0);
    send_sample(6'd0, 16'h8000, 1'b1, 0);
    send_sample(6'd0, 16'h7fff, 1'b1, 0);
    send_sample(6'd0, 16'hffff, 1'b0, 0);
    send_sample(6'd63, 16'h5555, 1'b1, 0);
    send_sample(6'd63, 16'haaaa, 1'b1, 0);
    send_sample(6'd63, 16'h0001, 1'b0, 0);
    for (int i = 0; i < 6; i++) send_sample(6'd1, 16'hffff, 1'b0, 0);
    send_sample(6'd1, 16'h8000, 1'b1, 0);
    send_sample(6'd1, 16'h8000, 1'b1, 0);

    // Length writes below the minimum and above the maximum are clamped.
    write_length(8'd0);
    for (int i = 0; i < 6; i++) send_sample(6'd2, 16'(i * 9000 - 20000), 1'b1, 0);
    write_length(8'd1);
    random_phase(60, 4);
    write_length(8'd255);
    random_phase(300, 2);
    write_length(8'd128);
    random_phase(150, 1);
    write_length(8'd2);
    random_phase(100, 64);
    write_length(8'd3);
    random_phase(100, 8);
    write_length(8'd129);
    drain();
    write_length(8'd7);
    random_phase(100, 16);

    drain();
    $display("Run covered %0d samples, %0d responses checked, %0d with statistics.",
             sent, board.checked, board.stats_seen);
    $display("Window lengths written: 0, 1, 255, 128, 2, 3, 129 and 7.");
    if (board.mismatches == 0 && board.pending_stats.size() == 0) begin
      $display("rolling_window_mean_variance_core_tb passed");
    end else begin
      $display("rolling_window_mean_variance_core_tb failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
